/* src/fpba_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// fit-policy block allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fpba_pkg;

	localparam int NUM_BLOCKS        = 16;
	localparam int SIZE_W            = 16;
	localparam int IDX_W             = $clog2(NUM_BLOCKS);
	localparam int CNT_W             = 16;
	localparam int BCNT_W            = 5;
	localparam int POL_W             = 2;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 5;
	localparam int IN_TDATA_W        = 40;
	localparam int OUT_TDATA_W       = 40;
	localparam int RESET_BLOCK_COUNT = 16;

	// fit policy codes; the unused code behaves as first fit
	localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POL_W-1:0] POL_WORST = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

	// command codes carried on the input tuser
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic limit_zero;
		logic scan_last;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

/* src/fit_policy_block_allocator.sv */
// Top level of the fit-policy block allocator: stream ports, configuration
// port, controller and datapath. Depends on fpba_pkg, fpba_ctrl, fpba_datapath.
//
// Usage:
//   The input stream carries one word per item. tuser selects load (0) or
//   allocate (1). A load word writes one block's capacity and restarts the
//   request numbering; it produces no output word. An allocate word scans
//   the first block_count blocks (clamped to 16), one block per cycle, then
//   writes back the chosen block, if any, and loads the output register;
//   no new word is taken until that is done. The capacity table has a
//   single read port, so the scan reads one block at a time.
//   The output register lets an item be taken while a result waits; a result
//   stalled by the receiver holds the write-back cycle of the next allocate
//   until the register frees.
//   Configuration writes are always ready and must only be issued while
//   idle. Reset clears the capacity table, the request counter, the policy
//   (first fit) and sets the block count to 16.
`timescale 1ns / 1ps
`default_nettype none
module fit_policy_block_allocator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [fpba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [fpba_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// block_index[3:0], block_size[19:4], request_size[35:20], zero pad
	input  wire logic [fpba_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// cmd
	input  wire logic                                 s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// chosen_block[3:0], remaining_after[19:4], request_number[35:20], zero pad
	output logic [fpba_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	// granted
	output logic                                      m_axis_tuser
);

	localparam int BS_LO = fpba_pkg::IDX_W;
	localparam int RS_LO = BS_LO + fpba_pkg::SIZE_W;
	localparam int OUT_USED = fpba_pkg::IDX_W + fpba_pkg::SIZE_W + fpba_pkg::CNT_W;

	fpba_pkg::ctl_t                 ctl;
	fpba_pkg::sts_t                 sts;
	logic [fpba_pkg::IDX_W-1:0]     out_block;
	logic [fpba_pkg::SIZE_W-1:0]    out_remaining;
	logic [fpba_pkg::CNT_W-1:0]     out_reqnum;

	assign cfg_ready = 1'b1;

	fpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.sts      (sts),
		.ctl      (ctl)
	);

	fpba_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_idx        (s_axis_tdata[BS_LO-1:0]),
		.in_bsize      (s_axis_tdata[RS_LO-1:BS_LO]),
		.in_rsize      (s_axis_tdata[RS_LO+fpba_pkg::SIZE_W-1:RS_LO]),
		.ctl           (ctl),
		.sts           (sts),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_granted   (m_axis_tuser),
		.out_block     (out_block),
		.out_remaining (out_remaining),
		.out_reqnum    (out_reqnum)
	);

	assign m_axis_tdata = {{(fpba_pkg::OUT_TDATA_W-OUT_USED){1'b0}},
		out_reqnum, out_remaining, out_block};

endmodule
`default_nettype wire

/* src/fpba_datapath.sv */
// Datapath: configuration registers, capacity table, scan registers,
// request counter and output register. Depends on fpba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpba_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [fpba_pkg::IDX_W-1:0]      in_idx,
	input  wire logic [fpba_pkg::SIZE_W-1:0]     in_bsize,
	input  wire logic [fpba_pkg::SIZE_W-1:0]     in_rsize,
	input  wire fpba_pkg::ctl_t                  ctl,
	output fpba_pkg::sts_t                       sts,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 out_granted,
	output logic [fpba_pkg::IDX_W-1:0]           out_block,
	output logic [fpba_pkg::SIZE_W-1:0]          out_remaining,
	output logic [fpba_pkg::CNT_W-1:0]           out_reqnum
);

	logic [fpba_pkg::POL_W-1:0]  policy_q;
	logic [fpba_pkg::BCNT_W-1:0] bcount_q;
	logic [fpba_pkg::BCNT_W-1:0] limit;
	logic [fpba_pkg::BCNT_W-1:0] limit_q;
	logic [fpba_pkg::SIZE_W-1:0] cap_q [fpba_pkg::NUM_BLOCKS];
	logic [fpba_pkg::CNT_W-1:0]  count_q;
	logic [fpba_pkg::IDX_W-1:0]  idx_q;
	logic                        found_q;
	logic [fpba_pkg::IDX_W-1:0]  best_idx_q;
	logic [fpba_pkg::SIZE_W-1:0] best_cap_q;
	logic [fpba_pkg::SIZE_W-1:0] need_q;
	logic [fpba_pkg::SIZE_W-1:0] cap_rd;
	logic [fpba_pkg::SIZE_W-1:0] remain;
	logic                        fits;
	logic                        take;
	logic                        out_valid_q;
	logic                        granted_q;
	logic [fpba_pkg::IDX_W-1:0]  block_q;
	logic [fpba_pkg::SIZE_W-1:0] remaining_q;
	logic [fpba_pkg::CNT_W-1:0]  reqnum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= fpba_pkg::POL_FIRST;
			bcount_q <= fpba_pkg::BCNT_W'(fpba_pkg::RESET_BLOCK_COUNT);
		end else if (cfg_we) begin
			case (cfg_index)
				fpba_pkg::CFG_FIT_POLICY:  policy_q <= cfg_data[fpba_pkg::POL_W-1:0];
				fpba_pkg::CFG_BLOCK_COUNT: bcount_q <= cfg_data[fpba_pkg::BCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the block count to the table depth
	assign limit = (bcount_q > fpba_pkg::BCNT_W'(fpba_pkg::NUM_BLOCKS)) ?
		fpba_pkg::BCNT_W'(fpba_pkg::NUM_BLOCKS) : bcount_q;

	assign cap_rd = cap_q[idx_q];
	assign fits   = (cap_rd >= need_q);
	assign take   = fits && (!found_q ||
		(policy_q == fpba_pkg::POL_BEST  && cap_rd < best_cap_q) ||
		(policy_q == fpba_pkg::POL_WORST && cap_rd > best_cap_q));
	assign remain = best_cap_q - need_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fpba_pkg::NUM_BLOCKS; i++) begin
				cap_q[i] <= '0;
			end
		end else if (ctl.load) begin
			cap_q[in_idx] <= in_bsize;
		end else if (ctl.finish && found_q) begin
			cap_q[best_idx_q] <= remain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.load) begin
			count_q <= '0;
		end else if (ctl.start && count_q != {fpba_pkg::CNT_W{1'b1}}) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.start) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (ctl.step) begin
			idx_q <= idx_q + 1'b1;
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			need_q  <= in_rsize;
			limit_q <= limit;
		end
		if (ctl.step && take) begin
			best_idx_q <= idx_q;
			best_cap_q <= cap_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			granted_q   <= found_q;
			block_q     <= found_q ? best_idx_q : '0;
			remaining_q <= found_q ? remain : '0;
			reqnum_q    <= count_q;
		end
	end

	assign sts.limit_zero = (limit == '0);
	assign sts.scan_last  = ({1'b0, idx_q} == limit_q - 1'b1);
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid     = out_valid_q;
	assign out_granted   = granted_q;
	assign out_block     = block_q;
	assign out_remaining = remaining_q;
	assign out_reqnum    = reqnum_q;

endmodule
`default_nettype wire

/* src/fpba_ctrl.sv */
// Controller: sequences load, scan and write-back of one item at a time.
// Depends on fpba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpba_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           in_cmd,
	input  wire fpba_pkg::sts_t sts,
	output fpba_pkg::ctl_t      ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign ctl.load   = accept && (in_cmd == fpba_pkg::CMD_LOAD);
	assign ctl.start  = accept && (in_cmd == fpba_pkg::CMD_ALLOC);
	assign ctl.step   = (state_q == ST_SCAN);
	assign ctl.finish = (state_q == ST_DONE) && !sts.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= sts.limit_zero ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/fpba_checker.sv */
// Port-level checker for the fit-policy block allocator, bound to the top
// level. Depends on fpba_pkg and fit_policy_block_allocator.
`timescale 1ns / 1ps
`default_nettype none
module fpba_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 s_axis_tvalid,
	input wire logic                                 s_axis_tready,
	input wire logic                                 s_axis_tuser,
	input wire logic                                 m_axis_tvalid,
	input wire logic                                 m_axis_tready,
	input wire logic [fpba_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input wire logic                                 m_axis_tuser
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// a refused request reports no block and no remainder
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[19:0] == 20'd0)
		else $error("refused request carries block data");

	// every result counts its own request
	a_reqnum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[35:20] != 16'd0)
		else $error("request number zero on a result");

	// an allocate word blocks input for at least the scan
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == fpba_pkg::CMD_ALLOC |=>
			!s_axis_tready)
		else $error("input accepted during an allocate");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
